[rtl/ssrq_pkg.sv]
// Package for the stable sorted ready queue: sizes, mode and status codes,
// item and memory entry types, and the sequencer state type.
// No dependencies.
package ssrq_pkg;

   // Queue geometry
   localparam int DEPTH    = 16;
   localparam int KEY_BITS = 32;
   localparam int ID_BITS  = 8;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W   = $clog2(DEPTH);

   // Operation codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_POP    = 2'd2;
   localparam logic [1:0] MODE_LOOKUP = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [1:0]          mode;
      logic [ID_BITS-1:0]  item_id;
      logic [KEY_BITS-1:0] item_key;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ID_BITS-1:0]  out_id;
      logic [KEY_BITS-1:0] out_key;
      logic [4:0]          entry_count;
   } rsp_type;

   // One queue position as held in the memory
   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_WALK,
      S_INS_PLACE,
      S_FIND,
      S_SHIFT,
      S_DONE
   } state_type;

endpackage

[rtl/stable_sorted_ready_queue.sv]
// One item at a time; the next is taken the cycle after the result register loads.
// Insert walks from the tail, one entry per cycle, shifting larger keys up;
// remove and pop walk from the head and close the gap; lookup stops at the
// first match. The entry memory (one read, one write a cycle) sets the pace. Reset clears
// the sequencer, entry count and result valid; the entry memory needs no clearing pass.
module stable_sorted_ready_queue
   import ssrq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   state_type            state_ff, state_in;
   logic [1:0]           mode_ff, mode_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           res_status_ff, res_status_in;
   logic [ID_BITS-1:0]   res_id_ff, res_id_in;
   logic [KEY_BITS-1:0]  res_key_ff, res_key_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   entry_type            rd_entry_ff;

   entry_type            entry_mem [DEPTH];
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   entry_type            wr_data;
   logic [ADDR_W-1:0]    rd_addr;

   logic                 accept;
   logic                 rsp_load;
   logic [CNT_W-1:0]     idx_plus;
   logic                 at_last;
   logic                 hit;
   entry_type            new_entry;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Walk helpers: next position, end of the held entries, match test
   assign idx_plus  = CNT_W'(idx_ff) + CNT_W'(1);
   assign at_last   = (idx_plus == count_ff);
   assign hit       = (mode_ff == MODE_POP) || (rd_entry_ff.id == id_ff);
   assign new_entry = '{id: id_ff, key: key_ff};
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_entry_ff <= entry_mem[rd_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_item.mode == MODE_INSERT) begin
                  if (count_ff == FULL_COUNT || count_ff == '0) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_INS_WALK;
                  end
               end else if (count_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FIND;
               end
            end
         end
         S_INS_WALK: begin
            if (rd_entry_ff.key > key_ff) begin
               if (idx_ff == '0) begin
                  state_in = S_INS_PLACE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_INS_PLACE: begin
            state_in = S_DONE;
         end
         S_FIND: begin
            if (hit) begin
               if (mode_ff == MODE_LOOKUP || at_last) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_SHIFT;
               end
            end else if (at_last) begin
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            if (at_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Datapath control and memory accesses per state
   always_comb begin
      mode_in       = mode_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_key_in    = res_key_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = new_entry;
      rd_addr       = idx_plus[ADDR_W-1:0];
      case (state_ff)
         S_IDLE: begin
            // Insert starts at the tail, the others at the head
            if (req_item.mode == MODE_INSERT) begin
               rd_addr = ADDR_W'(count_ff - CNT_W'(1));
            end else begin
               rd_addr = '0;
            end
            if (req_valid) begin
               mode_in       = req_item.mode;
               id_in         = req_item.item_id;
               key_in        = req_item.item_key;
               res_status_in = STATUS_OK;
               res_id_in     = '0;
               res_key_in    = '0;
               idx_in        = rd_addr;
               if (req_item.mode == MODE_INSERT) begin
                  if (count_ff == FULL_COUNT) begin
                     res_status_in = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = '{id: req_item.item_id, key: req_item.item_key};
                     count_in = CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_MISS;
               end
            end
         end
         S_INS_WALK: begin
            // Move a larger key up one place, or drop the new entry above it
            rd_addr = idx_ff - ADDR_W'(1);
            wr_en   = 1'b1;
            wr_addr = idx_plus[ADDR_W-1:0];
            if (rd_entry_ff.key > key_ff) begin
               wr_data = rd_entry_ff;
               idx_in  = idx_ff - ADDR_W'(1);
            end else begin
               wr_data  = new_entry;
               count_in = count_ff + CNT_W'(1);
            end
         end
         S_INS_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_entry;
            count_in = count_ff + CNT_W'(1);
         end
         S_FIND: begin
            // Read ahead one position while testing this one
            if (hit) begin
               res_id_in  = rd_entry_ff.id;
               res_key_in = rd_entry_ff.key;
               if (mode_ff != MODE_LOOKUP) begin
                  if (at_last) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     idx_in = idx_plus[ADDR_W-1:0];
                  end
               end
            end else if (at_last) begin
               res_status_in = STATUS_MISS;
            end else begin
               idx_in = idx_plus[ADDR_W-1:0];
            end
         end
         S_SHIFT: begin
            // Close the gap: move each later entry down one place
            wr_en   = 1'b1;
            wr_addr = idx_ff - ADDR_W'(1);
            wr_data = rd_entry_ff;
            if (at_last) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               idx_in = idx_plus[ADDR_W-1:0];
            end
         end
         S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_in.status      = res_status_ff;
         rsp_in.out_id      = res_id_ff;
         rsp_in.out_key     = res_key_ff;
         rsp_in.entry_count = 5'(count_ff);
         rsp_valid_in       = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and held item
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_key_ff    <= res_key_in;
      rsp_ff        <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) ||
          count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_FULL) |->
         (rsp_ff.entry_count == 5'(FULL_COUNT)))
      else $error("full status with spare room");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == S_IDLE) |-> (count_ff == '0))
      else $error("idle write outside empty insert");
`endif

endmodule
